// ----- rtl/bgs_pkg.sv -----
// bgs_pkg: shared types and constants of the bilinear grid sampler.
// Used by bgs_front, bgs_back and bilinear_grid_sampler_top.
package bgs_pkg;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_SCATTER = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   localparam logic CSR_HEIGHT = 1'b0;
   localparam logic CSR_WIDTH  = 1'b1;

   // classified item handed from front to back
   typedef struct packed {
      op_type             op;
      logic [6:0]         row;
      logic [6:0]         col;
      logic signed [15:0] pixel;
      logic signed [15:0] grad;
      logic               outside;
      logic signed [10:0] sy;   // floor row, may be -1
      logic signed [10:0] sx;
      logic [14:0]        fy;   // Q.15 fraction
      logic [14:0]        fx;
   } item_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_WAIT,
      BK_ACC,
      BK_DONE
   } back_state_type;

endpackage

// ----- rtl/bgs_front.sv -----
// bgs_front: accepts beats, maps grid coordinates to pixel units, queues items.
// Depends on bgs_pkg.
module bgs_front #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         op,
   input  logic [6:0]         row,
   input  logic [6:0]         col,
   input  logic signed [15:0] pixel,
   input  logic signed [15:0] grid_y,
   input  logic signed [15:0] grid_x,
   input  logic signed [15:0] upstream_grad,
   input  logic [7:0]         height,
   input  logic [7:0]         width,
   output logic               q_valid,
   input  logic               q_take,
   output bgs_pkg::item_type  q_item
);
   localparam int SW = $clog2(MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS) + 1;

   // stage 1 register: coordinate products
   logic               s1_ff, s1_in;
   logic [1:0]         op_ff;
   logic [6:0]         row_ff, col_ff;
   logic signed [15:0] pix_ff, grad_ff;
   logic signed [31:0] py_ff, px_ff;
   logic [SW-1:0]      h_ff, w_ff;

   // two entry queue
   bgs_pkg::item_type  qd_ff [2];
   logic [1:0]         cnt_ff;
   logic               rd_ff;

   function automatic logic [SW-1:0] eff(input logic [7:0] r, input int mx);
      logic [SW-1:0] s;
      s = (r == 8'd0) ? SW'(1) : SW'(r);
      if (32'(r) > mx) s = SW'(mx);
      return s;
   endfunction

   logic accept;
   logic [SW-1:0] h_e, w_e;
   assign accept = push && !full;
   assign h_e = eff(height, MAX_ROWS);
   assign w_e = eff(width, MAX_COLS);
   // one slot is reserved for the stage 1 item
   assign full = (32'(cnt_ff) + 32'(s1_ff)) >= 2;
   assign s1_in = accept;

   always_ff @(posedge clock) begin
      if (reset) s1_ff <= 1'b0;
      else s1_ff <= s1_in;
      if (accept) begin
         op_ff   <= op;
         row_ff  <= row;
         col_ff  <= col;
         pix_ff  <= pixel;
         grad_ff <= upstream_grad;
         h_ff    <= h_e;
         w_ff    <= w_e;
         py_ff   <= (32'(grid_y) + 32'sd16384) * $signed({1'b0, 31'(h_e - SW'(1))});
         px_ff   <= (32'(grid_x) + 32'sd16384) * $signed({1'b0, 31'(w_e - SW'(1))});
      end
   end

   // classification of the stage 1 item
   bgs_pkg::item_type it;
   logic signed [16:0] sy17, sx17;
   always_comb begin
      sy17 = 17'(py_ff >>> 15);
      sx17 = 17'(px_ff >>> 15);
      it.op      = bgs_pkg::op_type'(op_ff);
      it.row     = row_ff;
      it.col     = col_ff;
      it.pixel   = pix_ff;
      it.grad    = grad_ff;
      it.outside = (sy17 < -17'sd1) || (sy17 > $signed(17'(h_ff) - 17'sd1)) ||
                   (sx17 < -17'sd1) || (sx17 > $signed(17'(w_ff) - 17'sd1));
      it.sy = 11'(sy17);
      it.sx = 11'(sx17);
      it.fy = py_ff[14:0];
      it.fx = px_ff[14:0];
   end

   logic take;
   assign take = q_take && q_valid;
   assign q_valid = cnt_ff != 2'd0;
   assign q_item = qd_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + 2'(s1_ff) - 2'(take);
         if (take) rd_ff <= !rd_ff;
      end
      // write slot is read pointer plus count
      if (s1_ff) qd_ff[rd_ff ^ cnt_ff[0]] <= it;
   end

`ifndef ASSERT_OFF
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_room: assert property (@(posedge clock) disable iff (reset)
      s1_ff |-> (cnt_ff < 2'd2 || take)) else $error("no room for item");
   a_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> full) else $error("full not raised");
`endif
endmodule

// ----- rtl/bgs_back.sv -----
// bgs_back: executes queued items against the pixel and gradient stores.
// Depends on bgs_pkg.
module bgs_back #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_take,
   input  bgs_pkg::item_type  q_item,
   input  logic [7:0]         height,
   input  logic [7:0]         width,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_sample_value,
   output logic signed [31:0] rsp_gradient_value,
   output logic               rsp_point_outside,
   output logic               busy
);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW = $clog2(DEPTH);

   logic signed [15:0] img [DEPTH];
   logic signed [31:0] grd [DEPTH];

   bgs_pkg::back_state_type st_ff, st_in;
   bgs_pkg::item_type it_ff;
   logic [1:0]  k_ff, k_in;          // neighbour index {j,i}
   logic signed [47:0] acc_ff, acc_in;
   logic signed [15:0] imq_ff;
   logic signed [31:0] grq_ff;
   logic        nb_ok_ff;
   logic [AW-1:0] na_ff;
   logic signed [31:0] wt_ff;
   logic [AW-1:0] clr_ff, clr_in;    // gradient clear pointer after reset

   logic out_v_ff;
   logic signed [15:0] out_s_ff;
   logic signed [31:0] out_g_ff;
   logic out_o_ff;

   logic [10:0] h_e, w_e;
   assign h_e = (height == 8'd0) ? 11'd1 : (32'(height) > MAX_ROWS) ? 11'(MAX_ROWS) : 11'(height);
   assign w_e = (width == 8'd0) ? 11'd1 : (32'(width) > MAX_COLS) ? 11'(MAX_COLS) : 11'(width);

   // neighbour k of current item
   logic signed [11:0] ry, rx;
   logic nb_ok;
   logic [AW-1:0] na, da;
   logic direct_ok;
   logic signed [31:0] wt;
   logic [15:0] wy, wx;
   always_comb begin
      ry = 12'(it_ff.sy) + 12'(k_ff[0]);
      rx = 12'(it_ff.sx) + 12'(k_ff[1]);
      nb_ok = !it_ff.outside && ry >= 0 && ry <= $signed(12'(h_e) - 12'sd1) &&
              rx >= 0 && rx <= $signed(12'(w_e) - 12'sd1);
      na = AW'(ry) * AW'(MAX_COLS) + AW'(rx);
      wy = k_ff[0] ? 16'(it_ff.fy) : 16'd32768 - 16'(it_ff.fy);
      wx = k_ff[1] ? 16'(it_ff.fx) : 16'd32768 - 16'(it_ff.fx);
      wt = $signed({1'b0, 31'(wy * wx)});
      direct_ok = 32'(it_ff.row) < MAX_ROWS && 32'(it_ff.col) < MAX_COLS;
      da = AW'(32'(it_ff.row) * MAX_COLS + 32'(it_ff.col));
   end

   // read, wait, then accumulate or write back for each neighbour
   logic signed [47:0] prod;
   logic signed [47:0] rnd;
   logic signed [33:0] gsum;
   logic signed [31:0] gnew;
   always_comb begin
      prod = 48'(wt_ff) * 48'(it_ff.grad);
      rnd  = (prod + 48'sd536870912) >>> 30;
      gsum = 34'(grq_ff) + 34'(rnd);
      if (gsum > 34'sd2147483647) gnew = 32'h7fffffff;
      else if (gsum < -34'sd2147483648) gnew = 32'h80000000;
      else gnew = 32'(gsum);
   end

   logic signed [47:0] fin;
   logic signed [15:0] sat16;
   always_comb begin
      fin = (acc_ff + 48'sd536870912) >>> 30;
      if (fin > 48'sd32767) sat16 = 16'sh7fff;
      else if (fin < -48'sd32768) sat16 = 16'sh8000;
      else sat16 = 16'(fin);
   end

   logic out_free;
   assign out_free = !out_v_ff || rsp_pop;

   always_comb begin
      st_in = st_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      clr_in = clr_ff;
      q_take = 1'b0;
      unique case (st_ff)
         bgs_pkg::BK_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) st_in = bgs_pkg::BK_IDLE;
         end
         bgs_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               k_in = 2'd0;
               acc_in = '0;
               st_in = bgs_pkg::BK_READ;
            end
         end
         bgs_pkg::BK_READ: st_in = bgs_pkg::BK_WAIT;
         bgs_pkg::BK_WAIT: begin
            if (it_ff.op == bgs_pkg::OP_WRITE || it_ff.op == bgs_pkg::OP_READ)
               st_in = bgs_pkg::BK_DONE;
            else st_in = bgs_pkg::BK_ACC;
         end
         bgs_pkg::BK_ACC: begin
            if (nb_ok_ff && it_ff.op == bgs_pkg::OP_SAMPLE)
               acc_in = acc_ff + 48'(wt_ff) * 48'(imq_ff);
            if (k_ff == 2'd3) st_in = bgs_pkg::BK_DONE;
            else begin
               k_in = k_ff + 2'd1;
               st_in = bgs_pkg::BK_READ;
            end
         end
         bgs_pkg::BK_DONE: begin
            if (it_ff.op == bgs_pkg::OP_WRITE || it_ff.op == bgs_pkg::OP_SCATTER)
               st_in = bgs_pkg::BK_IDLE;
            else if (out_free) st_in = bgs_pkg::BK_IDLE;
         end
         default: st_in = bgs_pkg::BK_IDLE;
      endcase
   end

   // gradient store write port: clear pass, scatter write back, read and clear
   logic g_we;
   logic [AW-1:0] g_wa;
   logic signed [31:0] g_wd;
   always_comb begin
      g_we = 1'b0;
      g_wa = clr_ff;
      g_wd = '0;
      if (st_ff == bgs_pkg::BK_CLEAR) begin
         g_we = 1'b1;
      end else if (st_ff == bgs_pkg::BK_ACC && nb_ok_ff &&
                   it_ff.op == bgs_pkg::OP_SCATTER) begin
         g_we = 1'b1;
         g_wa = na_ff;
         g_wd = gnew;
      end else if (st_ff == bgs_pkg::BK_DONE && it_ff.op == bgs_pkg::OP_READ &&
                   direct_ok && out_free) begin
         g_we = 1'b1;
         g_wa = da;
      end
   end

   assign busy = st_ff != bgs_pkg::BK_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= bgs_pkg::BK_CLEAR;
         clr_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         if (st_ff == bgs_pkg::BK_DONE && out_free &&
             (it_ff.op == bgs_pkg::OP_SAMPLE || it_ff.op == bgs_pkg::OP_READ))
            out_v_ff <= 1'b1;
         else if (rsp_pop && out_v_ff)
            out_v_ff <= 1'b0;
      end
      k_ff <= k_in;
      acc_ff <= acc_in;
      if (q_take) it_ff <= q_item;
      // memory read port
      if (st_ff == bgs_pkg::BK_READ) begin
         imq_ff <= img[(it_ff.op == bgs_pkg::OP_WRITE || it_ff.op == bgs_pkg::OP_READ) ? da : na];
         grq_ff <= grd[(it_ff.op == bgs_pkg::OP_READ) ? da : na];
         nb_ok_ff <= nb_ok;
         na_ff <= na;
         wt_ff <= wt;
      end
      // memory write ports
      if (st_ff == bgs_pkg::BK_WAIT && it_ff.op == bgs_pkg::OP_WRITE && direct_ok)
         img[da] <= it_ff.pixel;
      if (g_we)
         grd[g_wa] <= g_wd;
      if (st_ff == bgs_pkg::BK_DONE && out_free) begin
         out_s_ff <= (it_ff.op == bgs_pkg::OP_SAMPLE && !it_ff.outside) ? sat16 : 16'sd0;
         out_g_ff <= (it_ff.op == bgs_pkg::OP_READ && direct_ok) ? grq_ff : 32'sd0;
         out_o_ff <= it_ff.op == bgs_pkg::OP_SAMPLE && it_ff.outside;
      end
   end

   assign rsp_empty = !out_v_ff;
   assign rsp_sample_value = out_s_ff;
   assign rsp_gradient_value = out_g_ff;
   assign rsp_point_outside = out_o_ff;

`ifndef ASSERT_OFF
   a_take: assert property (@(posedge clock) disable iff (reset)
      q_take |-> st_ff == bgs_pkg::BK_IDLE) else $error("take while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_pop |=> out_v_ff && $stable(out_g_ff)) else $error("result lost");
   a_k: assert property (@(posedge clock) disable iff (reset)
      st_ff == bgs_pkg::BK_ACC && k_ff != 2'd3 |=> st_ff == bgs_pkg::BK_READ)
      else $error("neighbour walk broken");
`endif
endmodule

// ----- rtl/bilinear_grid_sampler_top.sv -----
// bilinear_grid_sampler_top: bilinear sampler with pixel and gradient stores.
// Depends on bgs_pkg, bgs_front, bgs_back.
//
// channel | ports                         | beat when
// req     | req_* payload, push, full     | push && !full
// rsp     | rsp_* payload, empty, pop     | pop && !empty
// csr     | csr_we, csr_index, csr_data   | csr_we
//
// Front: a stage 1 register holds the coordinate products, from which the Q.15
// fraction and floor are formed; a two entry queue then holds the item for the back.
// Back: write/read items pass the read, wait and done states; sample and scatter
// walk four neighbours, each through store read, data wait, and accumulate or
// write back, then finish in done. A new item is taken only when the back is idle.
// Reset is synchronous; a pass over all MAX_ROWS*MAX_COLS (16384 by default)
// entries then clears the gradient store before the first item is taken.
// A held result stalls the back; the queue keeps the front accepting until full.
module bilinear_grid_sampler_top #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_op,
   input  logic [6:0]         req_row,
   input  logic [6:0]         req_col,
   input  logic signed [15:0] req_pixel,
   input  logic signed [15:0] req_grid_y,
   input  logic signed [15:0] req_grid_x,
   input  logic signed [15:0] req_upstream_grad,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_sample_value,
   output logic signed [31:0] rsp_gradient_value,
   output logic               rsp_point_outside,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [7:0]         csr_data
);
   logic [7:0] height_ff, width_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 8'd128;
         width_ff  <= 8'd128;
      end else if (csr_we) begin
         if (csr_index == bgs_pkg::CSR_HEIGHT) height_ff <= csr_data;
         else width_ff <= csr_data;
      end
   end

   logic q_valid, q_take, busy;
   bgs_pkg::item_type q_item;

   bgs_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
      .clock, .reset, .push, .full,
      .op(req_op), .row(req_row), .col(req_col), .pixel(req_pixel),
      .grid_y(req_grid_y), .grid_x(req_grid_x), .upstream_grad(req_upstream_grad),
      .height(height_ff), .width(width_ff),
      .q_valid, .q_take, .q_item
   );

   bgs_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_item,
      .height(height_ff), .width(width_ff),
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_sample_value, .rsp_gradient_value, .rsp_point_outside, .busy
   );

`ifndef ASSERT_OFF
   a_take: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid) else $error("take from empty queue");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      q_valid && !busy |-> q_take) else $error("back idle with work");
   a_out: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_point_outside && rsp_gradient_value != 32'sd0))
      else $error("mixed result");
`endif
endmodule
